### sv/mff_pkg.sv
`timescale 1ns / 1ps

package mff_pkg;

    localparam int TEMPLATE_BYTES = 8;
    localparam int SIZE_BITS      = 16;
    localparam int TB_IDX_BITS    = (TEMPLATE_BYTES > 1) ? $clog2(TEMPLATE_BYTES) : 1;
    localparam int LEN_W          = ((SIZE_BITS > 16) ? SIZE_BITS : 16) + 1;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    localparam logic [1:0] MODE_TEMPLATE = 2'd0;
    localparam logic [1:0] MODE_RANGE    = 2'd1;
    localparam logic [1:0] MODE_SLICE    = 2'd2;

    localparam logic [2:0] CFG_FILTER_MODE     = 3'd0;
    localparam logic [2:0] CFG_REQUIRED_LENGTH = 3'd1;
    localparam logic [2:0] CFG_FIELD_OFFSET    = 3'd2;
    localparam logic [2:0] CFG_COMPARE_COUNT   = 3'd3;
    localparam logic [2:0] CFG_TEMPLATE_BYTES  = 3'd4;
    localparam logic [2:0] CFG_RANGE_START     = 3'd5;
    localparam logic [2:0] CFG_RANGE_WIDTH     = 3'd6;
    localparam logic [2:0] CFG_SLICE_SIZE      = 3'd7;

    typedef struct packed {
        logic [1:0]  filter_mode;
        logic [15:0] required_length;
        logic [15:0] field_offset;
        logic [3:0]  compare_count;
        logic [63:0] template_bytes;
        logic [31:0] range_start;
        logic [31:0] range_width;
        logic [15:0] slice_size;
    } cfg_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic                 overflow;
        logic                 template_equal;
        logic [31:0]          range_word;
    } msg_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] slice_start;
        logic [15:0] slice_length;
        logic [15:0] message_size;
        logic        size_overflow;
    } result_t;

    function automatic logic [3:0] eff_count(input logic [3:0] cc);
        return (cc > 4'(TEMPLATE_BYTES)) ? 4'(TEMPLATE_BYTES) : cc;
    endfunction

endpackage

### sv/message_field_filter_core.sv
`timescale 1ns / 1ps
// result path: the last byte passes the input register, then its verdict is registered in the output buffer
// throughput: one byte per cycle unless the input stalls
// input stalls only on a last byte while two finished results wait at the output buffer
// reset: rst_n clears all configuration registers to zero and the message counters
// to their start values; output buffer comes up empty

module message_field_filter_core
    import mff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        matched,
    output logic [15:0] slice_start,
    output logic [15:0] slice_length,
    output logic [15:0] message_size,
    output logic        size_overflow
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       buf_full;
    logic       fire;
    logic       accept;
    msg_t       msg_next;
    result_t    result;
    result_t    out_data;

    assign fire     = in_valid_reg && (!last_reg || !buf_full);
    assign in_stall = in_valid_reg && last_reg && buf_full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_MODE:     cfg_reg.filter_mode     <= cfg_data[1:0];
                CFG_REQUIRED_LENGTH: cfg_reg.required_length <= cfg_data[15:0];
                CFG_FIELD_OFFSET:    cfg_reg.field_offset    <= cfg_data[15:0];
                CFG_COMPARE_COUNT:   cfg_reg.compare_count   <= cfg_data[3:0];
                CFG_TEMPLATE_BYTES:  cfg_reg.template_bytes  <= cfg_data;
                CFG_RANGE_START:     cfg_reg.range_start     <= cfg_data[31:0];
                CFG_RANGE_WIDTH:     cfg_reg.range_width     <= cfg_data[31:0];
                CFG_SLICE_SIZE:      cfg_reg.slice_size      <= cfg_data[15:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    mff_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .data_byte (data_reg),
        .last_byte (last_reg),
        .msg_next  (msg_next)
    );

    mff_verdict u_verdict (
        .cfg    (cfg_reg),
        .msg    (msg_next),
        .result (result)
    );

    mff_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && last_reg),
        .push_data (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign matched       = out_data.matched;
    assign slice_start   = out_data.slice_start;
    assign slice_length  = out_data.slice_length;
    assign message_size  = out_data.message_size;
    assign size_overflow = out_data.size_overflow;

endmodule

### sv/mff_accum.sv
`timescale 1ns / 1ps

module mff_accum
    import mff_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output msg_t       msg_next
);

    msg_t                   msg_reg;
    logic [LEN_W-1:0]       pos_w;
    logic [LEN_W-1:0]       off_w;
    logic [LEN_W-1:0]       rel;
    logic [TB_IDX_BITS-1:0] tb_idx;
    logic [7:0]             tb_byte;
    logic [3:0]             eff;

    assign pos_w   = LEN_W'(msg_reg.size);
    assign off_w   = LEN_W'(cfg.field_offset);
    assign rel     = pos_w - off_w;
    assign tb_idx  = rel[TB_IDX_BITS-1:0];
    assign tb_byte = cfg.template_bytes[{tb_idx, 3'b000} +: 8];
    assign eff     = eff_count(cfg.compare_count);

    always_comb
    begin
        msg_next = msg_reg;
        if (msg_reg.size == SIZE_MAX)
        begin
            msg_next.overflow = 1'b1;
        end
        else
        begin
            msg_next.size = msg_reg.size + SIZE_BITS'(1);
            if (pos_w >= off_w)
            begin
                if (cfg.filter_mode == MODE_TEMPLATE && rel < LEN_W'(eff))
                begin
                    if (tb_byte != data_byte)
                    begin
                        msg_next.template_equal = 1'b0;
                    end
                end
                else if (cfg.filter_mode == MODE_RANGE && rel < LEN_W'(4))
                begin
                    msg_next.range_word[{rel[1:0], 3'b000} +: 8] =
                        msg_reg.range_word[{rel[1:0], 3'b000} +: 8] | data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_reg <= '{size: '0, overflow: 1'b0, template_equal: 1'b1, range_word: '0};
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                msg_reg <= '{size: '0, overflow: 1'b0, template_equal: 1'b1,
                             range_word: '0};
            end
            else
            begin
                msg_reg <= msg_next;
            end
        end
    end

    a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        msg_reg.overflow |-> msg_reg.size == SIZE_MAX)
        else $error("overflow flag set below counter maximum");

endmodule

### sv/mff_verdict.sv
`timescale 1ns / 1ps

module mff_verdict
    import mff_pkg::*;
(
    input  cfg_t    cfg,
    input  msg_t    msg,
    output result_t result
);

    logic [LEN_W-1:0] size_w;
    logic [LEN_W-1:0] off_w;
    logic [31:0]      word_diff;
    logic             ok;

    assign size_w    = LEN_W'(msg.size);
    assign off_w     = LEN_W'(cfg.field_offset);
    assign word_diff = msg.range_word - cfg.range_start;

    always_comb
    begin
        ok                  = !msg.overflow;
        result.slice_start  = '0;
        result.slice_length = 16'(msg.size);
        if (cfg.required_length != '0 && size_w != LEN_W'(cfg.required_length))
        begin
            ok = 1'b0;
        end
        case (cfg.filter_mode)
            MODE_TEMPLATE:
            begin
                if (size_w < off_w + LEN_W'(eff_count(cfg.compare_count))
                    || !msg.template_equal)
                begin
                    ok = 1'b0;
                end
            end
            MODE_RANGE:
            begin
                if (size_w < off_w + LEN_W'(4) || !(word_diff < cfg.range_width))
                begin
                    ok = 1'b0;
                end
            end
            MODE_SLICE:
            begin
                result.slice_start  = cfg.field_offset;
                result.slice_length = cfg.slice_size;
                if (size_w < off_w + LEN_W'(cfg.slice_size))
                begin
                    ok = 1'b0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        result.matched       = ok;
        result.message_size  = 16'(msg.size);
        result.size_overflow = msg.overflow;
    end

endmodule

### sv/mff_out_buf.sv
`timescale 1ns / 1ps

module mff_out_buf
    import mff_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_data,
    output logic    full
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && !out_stall;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign full      = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result pushed into a full buffer");

endmodule

### dv/tb_message_field_filter_core.sv
`timescale 1ns / 1ps

module tb_message_field_filter_core;
    import mff_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_BYTES = 1900;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [63:0] val;
        logic [7:0]  b;
        logic        l;
        bit          typed;
        result_t     verdict;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        matched;
    logic [15:0] slice_start;
    logic [15:0] slice_length;
    logic [15:0] message_size;
    logic        size_overflow;

    // filter model state
    cfg_t        rule = '0;
    int unsigned msg_len = 0;
    bit          tmpl_ok = 1'b1;
    logic [31:0] gathered_word = '0;
    bit          len_ovf = 1'b0;

    result_t     pending_verdicts[$];
    result_t     seen_verdict;
    result_t     want_verdict;
    int          errors = 0;
    int          idle_cycles = 0;
    int          bytes_sent = 0;
    bit          quiet = 1'b0;

    message_field_filter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .matched      (matched),
        .slice_start  (slice_start),
        .slice_length (slice_length),
        .message_size (message_size),
        .size_overflow(size_overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit judge_byte(input logic [7:0] b, input logic l,
                                      output result_t r);
        int unsigned pos;
        int unsigned rel;
        int unsigned lim;
        int unsigned off;
        logic [31:0] diff;
        bit ok;
        r = '0;
        off = 32'(rule.field_offset);
        lim = (32'(rule.compare_count) > TEMPLATE_BYTES) ? TEMPLATE_BYTES
                                                         : 32'(rule.compare_count);
        if (msg_len >= 32'(SIZE_MAX))
        begin
            len_ovf = 1'b1;
        end
        else
        begin
            pos = msg_len;
            msg_len++;
            if (pos >= off)
            begin
                rel = pos - off;
                if (rule.filter_mode == MODE_TEMPLATE && rel < lim)
                begin
                    if (rule.template_bytes[8*rel +: 8] != b)
                        tmpl_ok = 1'b0;
                end
                else if (rule.filter_mode == MODE_RANGE && rel < 4)
                begin
                    gathered_word[8*rel +: 8] = b;
                end
            end
        end
        if (!l)
            return 1'b0;
        ok = !len_ovf;
        r.slice_start = '0;
        r.slice_length = msg_len[15:0];
        r.message_size = msg_len[15:0];
        r.size_overflow = len_ovf;
        if (rule.required_length != '0 && msg_len != 32'(rule.required_length))
            ok = 1'b0;
        case (rule.filter_mode)
            MODE_TEMPLATE:
            begin
                if (msg_len < off + lim || !tmpl_ok)
                    ok = 1'b0;
            end
            MODE_RANGE:
            begin
                diff = gathered_word - rule.range_start;
                if (msg_len < off + 4 || !(diff < rule.range_width))
                    ok = 1'b0;
            end
            MODE_SLICE:
            begin
                r.slice_start = rule.field_offset;
                r.slice_length = rule.slice_size;
                if (msg_len < off + 32'(rule.slice_size))
                    ok = 1'b0;
            end
            default:
                ok = 1'b0;
        endcase
        r.matched = ok;
        msg_len = 0;
        tmpl_ok = 1'b1;
        gathered_word = '0;
        len_ovf = 1'b0;
        return 1'b1;
    endfunction

    function automatic step_t cfg_row(input logic [2:0] idx, input logic [63:0] val);
        step_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    function automatic step_t byte_row(input logic [7:0] b);
        step_t s;
        s = '{default: '0};
        s.b = b;
        return s;
    endfunction

    function automatic step_t last_row(input logic [7:0] b, input bit typed,
                                       input result_t verdict);
        step_t s;
        s = '{default: '0};
        s.b = b;
        s.l = 1'b1;
        s.typed = typed;
        s.verdict = verdict;
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                             input result_t verdict);
        result_t r;
        cfg_we <= 1'b0;
        while (!quiet && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (judge_byte(b, l, r))
            pending_verdicts.push_back(typed ? verdict : r);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        logic [63:0] raw;
        int w;
        case (idx)
            CFG_FILTER_MODE:                                     w = 2;
            CFG_COMPARE_COUNT:                                   w = 4;
            CFG_REQUIRED_LENGTH, CFG_FIELD_OFFSET, CFG_SLICE_SIZE: w = 16;
            CFG_RANGE_START, CFG_RANGE_WIDTH:                    w = 32;
            default:                                             w = 64;
        endcase
        // unused upper bits carry noise
        raw = {$urandom, $urandom};
        for (int i = 0; i < w; i++)
            raw[i] = val[i];
        case (idx)
            CFG_FILTER_MODE:     rule.filter_mode = raw[1:0];
            CFG_REQUIRED_LENGTH: rule.required_length = raw[15:0];
            CFG_FIELD_OFFSET:    rule.field_offset = raw[15:0];
            CFG_COMPARE_COUNT:   rule.compare_count = raw[3:0];
            CFG_TEMPLATE_BYTES:  rule.template_bytes = raw;
            CFG_RANGE_START:     rule.range_start = raw[31:0];
            CFG_RANGE_WIDTH:     rule.range_width = raw[31:0];
            default:             rule.slice_size = raw[15:0];
        endcase
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= raw;
        @(posedge clk);
    endtask

    task automatic new_rule();
        logic [1:0] mode;
        logic [31:0] span;
        mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:       span = '0;
            1:       span = '1;
            2:       span = $urandom;
            default: span = $urandom_range(1, 256);
        endcase
        wait_idle();
        write_reg(CFG_FILTER_MODE, 64'(mode));
        write_reg(CFG_REQUIRED_LENGTH,
                  $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(1, 28)));
        write_reg(CFG_FIELD_OFFSET,
                  ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 10)));
        write_reg(CFG_COMPARE_COUNT, 64'($urandom_range(0, 15)));
        write_reg(CFG_TEMPLATE_BYTES, {$urandom, $urandom});
        write_reg(CFG_RANGE_START, 64'($urandom));
        write_reg(CFG_RANGE_WIDTH, 64'(span));
        write_reg(CFG_SLICE_SIZE, 64'($urandom_range(0, 16)));
    endtask

    task automatic random_message();
        logic [7:0] msg[$];
        int len;
        int lim;
        int flen;
        int off;
        logic [31:0] w;
        bit shaped;
        shaped = ($urandom_range(0, 99) < 70);
        off = int'(rule.field_offset);
        lim = (int'(rule.compare_count) > TEMPLATE_BYTES) ? TEMPLATE_BYTES
                                                          : int'(rule.compare_count);
        case (rule.filter_mode)
            MODE_TEMPLATE: flen = lim;
            MODE_RANGE:    flen = 4;
            MODE_SLICE:    flen = int'(rule.slice_size);
            default:       flen = 0;
        endcase
        if (!shaped)
            len = $urandom_range(1, 24);
        else if (rule.required_length != '0 && $urandom_range(0, 3) != 0)
            len = int'(rule.required_length);
        else
            len = off + flen + int'($urandom_range(0, 4));
        if (len == 0)
            len = 1;
        for (int i = 0; i < len; i++)
            msg.push_back(8'($urandom));
        if (rule.range_width != 0)
            w = rule.range_start + ($urandom % rule.range_width);
        else
            w = $urandom;
        // place the field so the rule can pass
        if (shaped)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (off + i < len)
                begin
                    if (rule.filter_mode == MODE_TEMPLATE)
                        msg[off + i] = rule.template_bytes[8*i +: 8];
                    else if (rule.filter_mode == MODE_RANGE && i < 4)
                        msg[off + i] = w[8*i +: 8];
                end
            end
        end
        for (int i = 0; i < len; i++)
        begin
            quiet = (bytes_sent >= 700 && bytes_sent < 1000);
            send_byte(msg[i], i == len - 1, 1'b0, '0);
            bytes_sent++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_verdict = '{matched, slice_start, slice_length, message_size, size_overflow};
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction m=%0d start=%0d len=%0d size=%0d ovf=%0d",
                         $time, matched, slice_start, slice_length, message_size,
                         size_overflow);
            end
            else
            begin
                want_verdict = pending_verdicts.pop_front();
                if (seen_verdict !== want_verdict)
                begin
                    errors++;
                    $display("%0t: expected m=%0d start=%0d len=%0d size=%0d ovf=%0d",
                             $time, want_verdict.matched, want_verdict.slice_start,
                             want_verdict.slice_length, want_verdict.message_size,
                             want_verdict.size_overflow);
                    $display("%0t: actual   m=%0d start=%0d len=%0d size=%0d ovf=%0d",
                             $time, matched, slice_start, slice_length, message_size,
                             size_overflow);
                end
            end
        end
        out_stall <= !quiet && ($urandom_range(0, 99) < 32);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        step_t directed[$];
        bit prev_cfg;
        directed = '{
            last_row(8'h00, 1'b1, result_t'({1'b1, 16'd0, 16'd1, 16'd1, 1'b0})),
            cfg_row(CFG_TEMPLATE_BYTES, 64'hFF00_FF00_FF00_FF00),
            cfg_row(CFG_COMPARE_COUNT, 64'd15),
            byte_row(8'h00), byte_row(8'hFF), byte_row(8'h00), byte_row(8'hFF),
            byte_row(8'h00), byte_row(8'hFF), byte_row(8'h00),
            last_row(8'hFF, 1'b1, result_t'({1'b1, 16'd0, 16'd8, 16'd8, 1'b0})),
            // too short for the template
            byte_row(8'h00), byte_row(8'hFF),
            last_row(8'h00, 1'b1, result_t'({1'b0, 16'd0, 16'd3, 16'd3, 1'b0})),
            // range wraps past zero
            cfg_row(CFG_FILTER_MODE, 64'(MODE_RANGE)),
            cfg_row(CFG_FIELD_OFFSET, 64'd1),
            cfg_row(CFG_RANGE_START, 64'hFFFF_FFF0),
            cfg_row(CFG_RANGE_WIDTH, 64'h20),
            byte_row(8'hA5), byte_row(8'h05), byte_row(8'h00), byte_row(8'h00),
            last_row(8'h00, 1'b0, '0),
            cfg_row(CFG_FILTER_MODE, 64'(MODE_SLICE)),
            cfg_row(CFG_FIELD_OFFSET, 64'd2),
            cfg_row(CFG_SLICE_SIZE, 64'd3),
            cfg_row(CFG_REQUIRED_LENGTH, 64'd5),
            byte_row(8'h11), byte_row(8'h22), byte_row(8'h33), byte_row(8'h44),
            last_row(8'h55, 1'b0, '0),
            cfg_row(CFG_FILTER_MODE, 64'(MODE_UNUSED)),
            cfg_row(CFG_REQUIRED_LENGTH, 64'd0),
            last_row(8'h5A, 1'b1, result_t'({1'b0, 16'd0, 16'd1, 16'd1, 1'b0}))
        };
        prev_cfg = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            if (directed[k].is_cfg)
            begin
                if (!prev_cfg)
                    wait_idle();
                write_reg(directed[k].idx, directed[k].val);
            end
            else
            begin
                send_byte(directed[k].b, directed[k].l, directed[k].typed,
                          directed[k].verdict);
            end
            prev_cfg = directed[k].is_cfg;
        end

        while (bytes_sent < RANDOM_BYTES)
        begin
            new_rule();
            repeat ($urandom_range(3, 12))
                random_message();
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
